// ===== design/lsps_pkg.sv =====
// lsps_pkg: shared types and constants of the LED strip pixel serializer.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package lsps_pkg;

   localparam int ColorW   = 24;
   localparam int IndexW   = 8;
   localparam int CountW   = 9;
   localparam int TicksW   = 8;
   localparam int LatchW   = 16;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;

   localparam logic [LatchW-1:0] IdleMax = '1;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_SHOW  = 2'd2,
      OP_TICK  = 2'd3
   } op_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_LED_COUNT  = 3'd0,
      CSR_SCALE      = 3'd1,
      CSR_ONE_HIGH   = 3'd2,
      CSR_ONE_LOW    = 3'd3,
      CSR_ZERO_HIGH  = 3'd4,
      CSR_ZERO_LOW   = 3'd5,
      CSR_LATCH      = 3'd6,
      CSR_UNUSED     = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic [TicksW-1:0] one_high;
      logic [TicksW-1:0] one_low;
      logic [TicksW-1:0] zero_high;
      logic [TicksW-1:0] zero_low;
      logic [LatchW-1:0] latch;
   } timing_type;

   typedef struct packed {
      logic line;
      logic busy;
      logic done;
   } ser_status_type;

endpackage

`default_nettype wire

// ===== design/lsps_if.sv =====
// Channel interfaces: request, response and register write port.
// Depends on lsps_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lsps_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    op;
   logic [lsps_pkg::IndexW-1:0]   index;
   logic [lsps_pkg::ColorW-1:0]   color;
   modport source (output valid, op, index, color, input ready);
   modport sink   (input valid, op, index, color, output ready);
endinterface

interface lsps_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lsps_pkg::ColorW-1:0]   read_color;
   logic                          line_out;
   logic                          busy_res;
   logic                          rejected;
   logic                          frame_done;
   modport source (output valid, read_color, line_out, busy_res, rejected, frame_done,
                   input ready);
   modport sink   (input valid, read_color, line_out, busy_res, rejected, frame_done,
                   output ready);
endinterface

interface lsps_csr_if;
   logic                          valid;
   logic                          ready;
   logic [lsps_pkg::CsrIdxW-1:0]  index;
   logic [lsps_pkg::CsrDataW-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/lsps_ram.sv =====
// lsps_ram: generic RAM, one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lsps_ram #(
   parameter  int WIDTH = 24,
   parameter  int DEPTH = 256,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [AW-1:0]        waddr,
   input  wire logic [WIDTH-1:0]     wdata,
   input  wire logic                 re_a,
   input  wire logic [AW-1:0]        raddr_a,
   output logic      [WIDTH-1:0]     qa,
   input  wire logic [AW-1:0]        raddr_b,
   output logic      [WIDTH-1:0]     qb
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re_a) begin
         qa <= mem[raddr_a];
      end
      qb <= mem[raddr_b];
   end

endmodule

`default_nettype wire

// ===== design/lsps_serializer.sv =====
// lsps_serializer: frame arming, latch gap and bit timing of the strip line.
// Depends on lsps_pkg; pixel data comes from the top level's store.
`timescale 1ns / 1ps
`default_nettype none

module lsps_serializer #(
   parameter int ADDR_W = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          tick_go,
   input  wire logic                          show_go,
   input  wire lsps_pkg::timing_type          timing,
   input  wire logic [lsps_pkg::CountW-1:0]   eff_count,
   input  wire logic [lsps_pkg::ColorW-1:0]   pixel,
   output logic                               busy,
   output lsps_pkg::ser_status_type           status_in,
   output logic      [ADDR_W-1:0]             pixel_addr_in
);
   localparam int CmpW = (ADDR_W + 1 > lsps_pkg::CountW) ? ADDR_W + 1 : lsps_pkg::CountW;

   logic [ADDR_W-1:0]               send_pixel_ff, send_pixel_in;
   logic [1:0]                      byte_sel_ff, byte_sel_in;
   logic [2:0]                      bit_sel_ff, bit_sel_in;
   logic                            phase_high_ff, phase_high_in;
   logic [lsps_pkg::TicksW-1:0]     phase_cnt_ff, phase_cnt_in;
   logic                            sending_ff, sending_in;
   logic                            pending_ff, pending_in;
   logic [lsps_pkg::LatchW-1:0]     idle_cnt_ff, idle_cnt_in;
   logic                            line_ff, line_in;

   logic [7:0]                      cur_byte;
   logic                            cur_bit;
   logic [lsps_pkg::TicksW-1:0]     lim;
   logic [lsps_pkg::TicksW:0]       cnt_inc;
   logic                            done;

   assign busy = sending_ff | pending_ff;

   always_comb begin
      send_pixel_in = send_pixel_ff;
      byte_sel_in   = byte_sel_ff;
      bit_sel_in    = bit_sel_ff;
      phase_high_in = phase_high_ff;
      phase_cnt_in  = phase_cnt_ff;
      sending_in    = sending_ff;
      pending_in    = pending_ff;
      idle_cnt_in   = idle_cnt_ff;
      line_in       = line_ff;
      done          = 1'b0;
      cur_byte      = '0;
      cur_bit       = 1'b0;
      lim           = '0;
      cnt_inc       = '0;

      if (show_go) begin
         pending_in = 1'b1;
      end

      if (tick_go) begin
         if (!sending_ff && pending_ff && (idle_cnt_ff >= timing.latch)) begin
            pending_in = 1'b0;
            if (eff_count != '0) begin
               sending_in    = 1'b1;
               send_pixel_in = '0;
               byte_sel_in   = '0;
               bit_sel_in    = 3'd7;
               phase_high_in = 1'b1;
               phase_cnt_in  = '0;
            end
         end

         if (sending_in) begin
            case (byte_sel_in)
               2'd0:    cur_byte = pixel[23:16];
               2'd1:    cur_byte = pixel[7:0];
               default: cur_byte = pixel[15:8];
            endcase
            cur_bit = cur_byte[bit_sel_in];
            if (phase_high_in) begin
               lim = cur_bit ? timing.one_high : timing.zero_high;
            end else begin
               lim = cur_bit ? timing.one_low : timing.zero_low;
            end
            if (lim == '0) begin
               lim = 8'd1;
            end
            line_in = phase_high_in;
            cnt_inc = {1'b0, phase_cnt_in} + 9'd1;
            if (cnt_inc >= {1'b0, lim}) begin
               phase_cnt_in = '0;
               if (phase_high_in) begin
                  phase_high_in = 1'b0;
               end else begin
                  phase_high_in = 1'b1;
                  if (bit_sel_in != 3'd0) begin
                     bit_sel_in = bit_sel_in - 3'd1;
                  end else begin
                     bit_sel_in = 3'd7;
                     if (byte_sel_in == 2'd2) begin
                        byte_sel_in = '0;
                        if ((CmpW'(send_pixel_in) + CmpW'(1)) >= CmpW'(eff_count)) begin
                           sending_in    = 1'b0;
                           phase_high_in = 1'b0;
                           send_pixel_in = '0;
                           idle_cnt_in   = '0;
                           done          = 1'b1;
                        end else begin
                           send_pixel_in = send_pixel_in + ADDR_W'(1);
                        end
                     end else begin
                        byte_sel_in = byte_sel_in + 2'd1;
                     end
                  end
               end
            end else begin
               phase_cnt_in = cnt_inc[lsps_pkg::TicksW-1:0];
            end
         end else begin
            line_in = 1'b0;
            if (idle_cnt_in != lsps_pkg::IdleMax) begin
               idle_cnt_in = idle_cnt_in + 16'd1;
            end
         end
      end
   end

   assign pixel_addr_in    = send_pixel_in;
   assign status_in.line   = line_in;
   assign status_in.busy   = sending_in | pending_in;
   assign status_in.done   = done;

   always_ff @(posedge clock) begin
      if (reset) begin
         send_pixel_ff <= '0;
         byte_sel_ff   <= '0;
         bit_sel_ff    <= 3'd7;
         phase_high_ff <= 1'b0;
         phase_cnt_ff  <= '0;
         sending_ff    <= 1'b0;
         pending_ff    <= 1'b0;
         idle_cnt_ff   <= lsps_pkg::IdleMax;
         line_ff       <= 1'b0;
      end else begin
         send_pixel_ff <= send_pixel_in;
         byte_sel_ff   <= byte_sel_in;
         bit_sel_ff    <= bit_sel_in;
         phase_high_ff <= phase_high_in;
         phase_cnt_ff  <= phase_cnt_in;
         sending_ff    <= sending_in;
         pending_ff    <= pending_in;
         idle_cnt_ff   <= idle_cnt_in;
         line_ff       <= line_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/led_strip_pixel_serializer_core.sv =====
// led_strip_pixel_serializer_core: pixel store, request pipeline and registers.
// Depends on lsps_pkg, lsps_if, lsps_ram and lsps_serializer.
//
// Usage:
//  req_chan carries one transaction per operation: write pixel, read pixel,
//  show frame or one line tick. Every transaction produces exactly one
//  transaction on rsp_chan with the read color, the line level after the
//  operation, the busy flag, a reject flag and a frame-done pulse.
//  csr_chan writes the seven configuration registers by index; it is always
//  ready and is meant to be used only while the block is idle.
//  Responses pass stage 1 and the output register, since the store's read
//  port is registered. Throughput is one transaction per cycle unless rsp_chan
//  stalls; all state updates for a transaction happen in the cycle it is taken.
//  After reset the pixel store is zeroed by a clearing pass over all MAX_LEDS
//  entries during which req_chan.ready stays low; register writes are taken.
//  When rsp_chan stalls, the two pipeline stages hold and req_chan.ready
//  drops once both are full; nothing is lost or repeated.
//  The serializer reads the current pixel from a second read port of the
//  store, addressed with the next pixel number, with a bypass for a write to
//  that same pixel.
`timescale 1ns / 1ps
`default_nettype none

module led_strip_pixel_serializer_core #(
   parameter int MAX_LEDS = 256
) (
   input  wire logic   clock,
   input  wire logic   reset,
   lsps_req_if.sink    req_chan,
   lsps_rsp_if.source  rsp_chan,
   lsps_csr_if.sink    csr_chan
);
   localparam int AddrW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int CW    = lsps_pkg::ColorW;

   // configuration registers
   logic [lsps_pkg::CountW-1:0] led_count_ff;
   logic [7:0]                  scale_ff;
   lsps_pkg::timing_type        timing_ff;
   logic                        csr_we;

   assign csr_chan.ready = 1'b1;
   assign csr_we         = csr_chan.valid & csr_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff        <= 9'd256;
         scale_ff            <= 8'd0;
         timing_ff.one_high  <= 8'd22;
         timing_ff.one_low   <= 8'd9;
         timing_ff.zero_high <= 8'd9;
         timing_ff.zero_low  <= 8'd22;
         timing_ff.latch     <= 16'd320;
      end else if (csr_we) begin
         unique case (lsps_pkg::csr_idx_type'(csr_chan.index))
            lsps_pkg::CSR_LED_COUNT: led_count_ff        <= csr_chan.data[8:0];
            lsps_pkg::CSR_SCALE:     scale_ff            <= csr_chan.data[7:0];
            lsps_pkg::CSR_ONE_HIGH:  timing_ff.one_high  <= csr_chan.data[7:0];
            lsps_pkg::CSR_ONE_LOW:   timing_ff.one_low   <= csr_chan.data[7:0];
            lsps_pkg::CSR_ZERO_HIGH: timing_ff.zero_high <= csr_chan.data[7:0];
            lsps_pkg::CSR_ZERO_LOW:  timing_ff.zero_low  <= csr_chan.data[7:0];
            lsps_pkg::CSR_LATCH:     timing_ff.latch     <= csr_chan.data;
            default: ;
         endcase
      end
   end

   logic [lsps_pkg::CountW-1:0] eff_count;
   assign eff_count = (int'(led_count_ff) > MAX_LEDS) ? lsps_pkg::CountW'(MAX_LEDS)
                                                     : led_count_ff;

   // clearing pass after reset
   logic             clr_active_ff, clr_active_in;
   logic [AddrW-1:0] clr_cnt_ff, clr_cnt_in;

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_cnt_in    = clr_cnt_ff;
      if (clr_active_ff) begin
         if (clr_cnt_ff == AddrW'(MAX_LEDS - 1)) begin
            clr_active_in = 1'b0;
         end else begin
            clr_cnt_in = clr_cnt_ff + AddrW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_cnt_ff    <= clr_cnt_in;
      end
   end

   // pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic s1_adv;
   logic accept;

   assign s1_adv         = s1_valid_ff & (~out_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~clr_active_ff & (~s1_valid_ff | s1_adv);
   assign accept         = req_chan.valid & req_chan.ready;

   // request decode
   lsps_pkg::op_type req_op;
   logic             in_range;
   logic             busy;
   logic             is_write, is_read, is_show, is_tick;
   logic [AddrW+7:0] idx_wide;
   logic [AddrW-1:0] idx_addr;
   logic [CW-1:0]    scaled;
   logic [15:0]      prod_r, prod_g, prod_b;

   assign req_op   = lsps_pkg::op_type'(req_chan.op);
   assign in_range = {1'b0, req_chan.index} < eff_count;
   assign idx_wide = {{AddrW{1'b0}}, req_chan.index};
   assign idx_addr = idx_wide[AddrW-1:0];

   always_comb begin
      is_write = 1'b0;
      is_read  = 1'b0;
      is_show  = 1'b0;
      is_tick  = 1'b0;
      unique case (req_op)
         lsps_pkg::OP_WRITE: is_write = 1'b1;
         lsps_pkg::OP_READ:  is_read  = 1'b1;
         lsps_pkg::OP_SHOW:  is_show  = 1'b1;
         lsps_pkg::OP_TICK:  is_tick  = 1'b1;
         default: ;
      endcase
   end

   assign prod_r = req_chan.color[23:16] * scale_ff;
   assign prod_g = req_chan.color[15:8] * scale_ff;
   assign prod_b = req_chan.color[7:0] * scale_ff;
   assign scaled = (scale_ff == 8'd0) ? req_chan.color
                                      : {prod_r[15:8], prod_g[15:8], prod_b[15:8]};

   // serializer
   lsps_pkg::ser_status_type ser_status_in;
   logic [AddrW-1:0]         pix_addr_in;
   logic [CW-1:0]            pixel;

   lsps_serializer #(
      .ADDR_W (AddrW)
   ) u_ser (
      .clock         (clock),
      .reset         (reset),
      .tick_go       (accept & is_tick),
      .show_go       (accept & is_show & ~busy),
      .timing        (timing_ff),
      .eff_count     (eff_count),
      .pixel         (pixel),
      .busy          (busy),
      .status_in     (ser_status_in),
      .pixel_addr_in (pix_addr_in)
   );

   // pixel store
   logic             mem_we;
   logic [AddrW-1:0] mem_waddr;
   logic [CW-1:0]    mem_wdata;
   logic [CW-1:0]    mem_qa, mem_qb;
   logic             byp_ff, byp_in;
   logic [CW-1:0]    byp_data_ff;

   assign mem_we    = clr_active_ff | (accept & is_write & ~busy & in_range);
   assign mem_waddr = clr_active_ff ? clr_cnt_ff : idx_addr;
   assign mem_wdata = clr_active_ff ? '0 : scaled;
   assign byp_in    = mem_we & (mem_waddr == pix_addr_in);
   assign pixel     = byp_ff ? byp_data_ff : mem_qb;

   lsps_ram #(
      .WIDTH (CW),
      .DEPTH (MAX_LEDS)
   ) u_store (
      .clock   (clock),
      .we      (mem_we),
      .waddr   (mem_waddr),
      .wdata   (mem_wdata),
      .re_a    (accept),
      .raddr_a (idx_addr),
      .qa      (mem_qa),
      .raddr_b (pix_addr_in),
      .qb      (mem_qb)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= byp_in;
      end
      byp_data_ff <= mem_wdata;
   end

   // stage 1 and output registers
   logic                     s1_rd_ff;
   logic                     s1_rej_ff;
   lsps_pkg::ser_status_type s1_status_ff;
   logic [CW-1:0]            out_color_ff;
   logic                     out_rej_ff;
   lsps_pkg::ser_status_type out_status_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (accept) begin
         s1_rd_ff     <= is_read & in_range;
         s1_rej_ff    <= (is_write | is_show) & busy;
         s1_status_ff <= ser_status_in;
      end
      if (s1_adv) begin
         out_color_ff  <= s1_rd_ff ? mem_qa : '0;
         out_rej_ff    <= s1_rej_ff;
         out_status_ff <= s1_status_ff;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.read_color = out_color_ff;
   assign rsp_chan.line_out   = out_status_ff.line;
   assign rsp_chan.busy_res   = out_status_ff.busy;
   assign rsp_chan.rejected   = out_rej_ff;
   assign rsp_chan.frame_done = out_status_ff.done;

   // checks
   a_line_implies_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.line_out) |-> rsp_chan.busy_res)
      else $error("line high while not busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.frame_done) |-> (!rsp_chan.busy_res && !rsp_chan.line_out))
      else $error("frame done while still busy or line high");

   a_no_write_while_busy: assert property (@(posedge clock) disable iff (reset)
      (mem_we && !clr_active_ff) |-> !busy)
      else $error("pixel store written during a frame");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_status_ff) && $stable(mem_qa)))
      else $error("stalled stage lost its contents");

endmodule

`default_nettype wire
